// ===== rtl/core/efbd_pkg.sv =====
package efbd_pkg;

    localparam int BYTE_W = 8;
    localparam int FRAME_MAX_DEFAULT = 64;

    // configuration port
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_CODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_CODE = 1'd1;

    localparam logic [BYTE_W-1:0] ESCAPE_CODE_RESET = 8'h48;
    localparam logic [BYTE_W-1:0] START_CODE_RESET = 8'h10;

endpackage

// ===== rtl/core/efbd_if.sv =====
interface efbd_rx_if;
    import efbd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface efbd_tx_if;
    import efbd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] payload_byte;
    logic              frame_last;

    modport source (output valid, output payload_byte, output frame_last, input ready);
    modport sink (input valid, input payload_byte, input frame_last, output ready);
endinterface

// ===== rtl/core/efbd_ram.sv =====
module efbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        // read data holds until the next read
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/escape_framed_byte_deframer.sv =====
// the first byte of a frame reaches tx through the drain state, the frame ram read register
// and the tx register once the closing delimiter byte is accepted, then one byte per cycle while tx is ready
// throughput: one rx byte per cycle while parsing; rx stalls while a frame drains
// from the single-port-read frame ram
// reset: parser hunts for an escape, codes return to 0x48 and 0x10, tx is empty;
// frame ram contents are not cleared (only bytes of the current frame are read)
module escape_framed_byte_deframer #(
    parameter int FRAME_MAX = efbd_pkg::FRAME_MAX_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    efbd_rx_if.sink                          rx,
    efbd_tx_if.source                        tx,
    input  logic                             cfg_we,
    input  logic [efbd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [efbd_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import efbd_pkg::*;

    localparam int AW = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1;
    localparam int CW = $clog2(FRAME_MAX + 1);
    localparam logic [CW-1:0] FILL_FULL = CW'(FRAME_MAX);

    typedef enum logic [4:0] {
        ST_HUNT      = 5'b00001,
        ST_HUNT_ESC  = 5'b00010,
        ST_FRAME     = 5'b00100,
        ST_FRAME_ESC = 5'b01000,
        ST_DRAIN     = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     fill_count_reg, fill_count_next;
    logic [CW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [BYTE_W-1:0] escape_code_reg, start_code_reg;
    logic              ram_valid_reg, ram_valid_next;
    logic              ram_last_reg, ram_last_next;
    logic              tx_valid_reg, tx_valid_next;
    logic [BYTE_W-1:0] tx_byte_reg;
    logic              tx_last_reg;

    logic              rx_fire;
    logic              ram_wr_en;
    logic              ram_rd_en;
    logic [BYTE_W-1:0] ram_rd_data;
    logic              move;
    logic              is_escape, is_start;

    assign rx.ready  = (state_reg != ST_DRAIN);
    assign rx_fire   = rx.valid && rx.ready;
    assign is_escape = (rx.rx_byte == escape_code_reg);
    assign is_start  = (rx.rx_byte == start_code_reg);

    // ram output to tx register
    assign move = ram_valid_reg && (!tx_valid_reg || tx.ready);

    assign ram_rd_en = (state_reg == ST_DRAIN) && (rd_ptr_reg != fill_count_reg)
                       && (!ram_valid_reg || move);

    always_comb
    begin
        state_next      = state_reg;
        fill_count_next = fill_count_reg;
        rd_ptr_next     = rd_ptr_reg;
        ram_wr_en       = 1'b0;
        case (state_reg)
            ST_HUNT:
            begin
                if (rx_fire && is_escape)
                begin
                    state_next = ST_HUNT_ESC;
                end
            end
            ST_HUNT_ESC:
            begin
                if (rx_fire)
                begin
                    if (is_start)
                    begin
                        fill_count_next = '0;
                        state_next      = ST_FRAME;
                    end
                    else
                    begin
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_FRAME:
            begin
                if (rx_fire)
                begin
                    if (is_escape)
                    begin
                        state_next = ST_FRAME_ESC;
                    end
                    else if (fill_count_reg >= FILL_FULL)
                    begin
                        fill_count_next = '0;
                        state_next      = ST_HUNT;
                    end
                    else
                    begin
                        ram_wr_en       = 1'b1;
                        fill_count_next = fill_count_reg + 1'b1;
                    end
                end
            end
            ST_FRAME_ESC:
            begin
                if (rx_fire)
                begin
                    // start test wins when both codes are equal
                    if (is_start)
                    begin
                        rd_ptr_next = '0;
                        state_next  = (fill_count_reg != '0) ? ST_DRAIN : ST_HUNT;
                    end
                    else if (is_escape && (fill_count_reg < FILL_FULL))
                    begin
                        ram_wr_en       = 1'b1;
                        fill_count_next = fill_count_reg + 1'b1;
                        state_next      = ST_FRAME;
                    end
                    else
                    begin
                        // loss of sync or overflow
                        fill_count_next = '0;
                        state_next      = ST_HUNT;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (ram_rd_en)
                begin
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                    if (rd_ptr_next == fill_count_reg)
                    begin
                        state_next = ST_HUNT;
                    end
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

    always_comb
    begin
        ram_valid_next = ram_valid_reg;
        ram_last_next  = ram_last_reg;
        tx_valid_next  = tx_valid_reg;
        if (move)
        begin
            ram_valid_next = 1'b0;
        end
        if (ram_rd_en)
        begin
            ram_valid_next = 1'b1;
            ram_last_next  = ((rd_ptr_reg + 1'b1) == fill_count_reg);
        end
        if (move)
        begin
            tx_valid_next = 1'b1;
        end
        else if (tx.ready)
        begin
            tx_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_HUNT;
            fill_count_reg  <= '0;
            rd_ptr_reg      <= '0;
            escape_code_reg <= ESCAPE_CODE_RESET;
            start_code_reg  <= START_CODE_RESET;
            ram_valid_reg   <= 1'b0;
            ram_last_reg    <= 1'b0;
            tx_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_count_reg <= fill_count_next;
            rd_ptr_reg     <= rd_ptr_next;
            ram_valid_reg  <= ram_valid_next;
            ram_last_reg   <= ram_last_next;
            tx_valid_reg   <= tx_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ESCAPE_CODE: escape_code_reg <= cfg_data;
                    CFG_START_CODE:  start_code_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            tx_byte_reg <= ram_rd_data;
            tx_last_reg <= ram_last_reg;
        end
    end

    assign tx.valid        = tx_valid_reg;
    assign tx.payload_byte = tx_byte_reg;
    assign tx.frame_last   = tx_last_reg;

    efbd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FRAME_MAX),
        .AW    (AW)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (fill_count_reg[AW-1:0]),
        .wr_data (rx.rx_byte),
        .rd_en   (ram_rd_en),
        .rd_addr (rd_ptr_reg[AW-1:0]),
        .rd_data (ram_rd_data)
    );

    a_rd_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        ram_rd_en |-> (rd_ptr_reg < fill_count_reg))
        else $error("frame ram read beyond buffered bytes");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= FILL_FULL)
        else $error("fill count above frame size");

    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> (fill_count_reg != '0))
        else $error("drain started on an empty frame");

    a_no_write_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (state_reg != ST_DRAIN) && !ram_rd_en)
        else $error("frame ram written while draining");

    a_last_item_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_rd_en && ((rd_ptr_reg + 1'b1) == fill_count_reg)) |=> (state_reg == ST_HUNT))
        else $error("drain did not end after the final read");

endmodule

// ===== bench/tb.sv =====
module tb;
    import efbd_pkg::*;

    localparam int FRAME_MAX = FRAME_MAX_DEFAULT;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT = 8;

    typedef enum logic [1:0] {
        HUNT,
        HUNT_ESC,
        IN_FRAME,
        FRAME_ESC
    } parse_phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } payload_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    efbd_rx_if rx_ch ();
    efbd_tx_if tx_ch ();

    escape_framed_byte_deframer #(
        .FRAME_MAX(FRAME_MAX)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .rx(rx_ch),
        .tx(tx_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // deframer model state
    logic [BYTE_W-1:0] esc_m;
    logic [BYTE_W-1:0] start_m;
    parse_phase_t      phase_m;
    logic [BYTE_W-1:0] frame_buf [FRAME_MAX];
    int                fill_m;

    payload_t expected_payload [$];

    int mismatch_count;
    int cycle_count;
    int items_sent;
    int src_idle_pct;
    int snk_stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("escape_framed_byte_deframer test failed");
            $finish;
        end
    end

    function automatic void buffer_byte(input logic [BYTE_W-1:0] b);
        if (fill_m >= FRAME_MAX)
        begin
            // overflow drops the whole frame
            fill_m = 0;
            phase_m = HUNT;
        end
        else
        begin
            frame_buf[fill_m] = b;
            fill_m++;
            phase_m = IN_FRAME;
        end
    endfunction

    function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
        payload_t p;
        int k;
        case (phase_m)
            HUNT:
            begin
                if (b == esc_m)
                    phase_m = HUNT_ESC;
            end
            HUNT_ESC:
            begin
                if (b == start_m)
                begin
                    fill_m = 0;
                    phase_m = IN_FRAME;
                end
                else
                    phase_m = HUNT;
            end
            IN_FRAME:
            begin
                if (b == esc_m)
                    phase_m = FRAME_ESC;
                else
                    buffer_byte(b);
            end
            FRAME_ESC:
            begin
                // start test wins when the codes are equal
                if (b == start_m)
                begin
                    for (k = 0; k < fill_m; k++)
                    begin
                        p.data = frame_buf[k];
                        p.last = (k + 1 == fill_m);
                        expected_payload.push_back(p);
                    end
                    fill_m = 0;
                    phase_m = HUNT;
                end
                else if (b == esc_m)
                    buffer_byte(b);
                else
                begin
                    fill_m = 0;
                    phase_m = HUNT;
                end
            end
        endcase
    endfunction

    // tx checker, sampled at the rising edge
    always @(posedge clk)
    begin : check_tx
        payload_t want;
        if (rst_n && tx_ch.valid && tx_ch.ready)
        begin
            if (expected_payload.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected item: payload_byte %h frame_last %b",
                             tx_ch.payload_byte, tx_ch.frame_last);
            end
            else
            begin
                want = expected_payload.pop_front();
                if (tx_ch.payload_byte !== want.data || tx_ch.frame_last !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %h/%b got %h/%b",
                                 want.data, want.last, tx_ch.payload_byte,
                                 tx_ch.frame_last);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
            tx_ch.ready = ($urandom_range(99) >= snk_stall_pct);
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            rx_ch.valid = 1'b0;
            @(negedge clk);
        end
        rx_ch.valid = 1'b1;
        rx_ch.rx_byte = b;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        deframe_byte(b);
        items_sent++;
        @(negedge clk);
    endtask

    // one payload byte, stuffed where it equals the escape code (bit 0 flipped instead when the codes are equal)
    task automatic send_payload_byte(input logic [BYTE_W-1:0] b);
        if (b == esc_m && esc_m != start_m)
        begin
            send_byte(esc_m);
            send_byte(esc_m);
        end
        else if (b == esc_m)
            send_byte(b ^ 8'h01);
        else
            send_byte(b);
    endtask

    task automatic send_frame(input int len);
        int k;
        send_byte(esc_m);
        send_byte(start_m);
        for (k = 0; k < len; k++)
            send_payload_byte(BYTE_W'($urandom_range(255)));
        send_byte(esc_m);
        send_byte(start_m);
    endtask

    task automatic wait_results_drained();
        rx_ch.valid = 1'b0;
        while (expected_payload.size() != 0)
            @(negedge clk);
    endtask

    task automatic wait_idle();
        wait_results_drained();
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        if (idx == CFG_ESCAPE_CODE)
            esc_m = val;
        else if (idx == CFG_START_CODE)
            start_m = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic test_reset_code_frames();
        src_idle_pct = 0;
        snk_stall_pct = 0;
        // hunting ignores plain bytes
        send_byte(8'h00);
        send_byte(8'hFF);
        // escape then non-start while hunting, and a lone start
        send_byte(ESCAPE_CODE_RESET);
        send_byte(8'h55);
        send_byte(START_CODE_RESET);
        // second escape is consumed, not taken as a new escape
        send_byte(ESCAPE_CODE_RESET);
        send_byte(ESCAPE_CODE_RESET);
        send_byte(START_CODE_RESET);
        // frame with extremes, start code as data and a literal escape
        send_byte(ESCAPE_CODE_RESET);
        send_byte(START_CODE_RESET);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(START_CODE_RESET);
        send_byte(ESCAPE_CODE_RESET);
        send_byte(ESCAPE_CODE_RESET);
        send_byte(8'hA5);
        send_byte(ESCAPE_CODE_RESET);
        send_byte(START_CODE_RESET);
        // closing pair does not open the next frame
        send_byte(8'h33);
        // empty frame
        send_byte(ESCAPE_CODE_RESET);
        send_byte(START_CODE_RESET);
        send_byte(ESCAPE_CODE_RESET);
        send_byte(START_CODE_RESET);
        // loss of sync
        send_byte(ESCAPE_CODE_RESET);
        send_byte(START_CODE_RESET);
        send_byte(8'h11);
        send_byte(ESCAPE_CODE_RESET);
        send_byte(8'h99);
        send_byte(8'h44);
        send_frame(1);
        wait_idle();
    endtask

    task automatic test_overflow();
        int k;
        src_idle_pct = 0;
        snk_stall_pct = 46;
        // full buffer closes normally
        send_frame(FRAME_MAX);
        // one byte too many drops the frame, closing pair then opens a new one
        send_frame(FRAME_MAX + 1);
        send_byte(8'h5A);
        send_byte(esc_m);
        send_byte(start_m);
        // overflow on a literal escape
        send_byte(esc_m);
        send_byte(start_m);
        for (k = 0; k < FRAME_MAX; k++)
            send_payload_byte(BYTE_W'($urandom_range(255)));
        send_byte(esc_m);
        send_byte(esc_m);
        send_frame(3);
        wait_idle();
    endtask

    task automatic test_equal_codes();
        src_idle_pct = 0;
        snk_stall_pct = 0;
        write_reg(CFG_ESCAPE_CODE, 8'h7E);
        write_reg(CFG_START_CODE, 8'h7E);
        send_byte(8'h7E);
        send_byte(8'h7E);
        send_byte(8'h01);
        send_byte(8'h7E);
        send_byte(8'h7E);
        send_byte(8'h7E);
        send_byte(8'h00);
        send_byte(8'h7E);
        send_byte(8'h7E);
        send_byte(8'h11);
        send_byte(8'h7E);
        send_byte(8'h22);
        send_frame(5);
        wait_idle();
    endtask

    task automatic test_random_traffic(input logic [BYTE_W-1:0] esc_val,
                                       input logic [BYTE_W-1:0] start_val,
                                       input int src_pct, input int snk_pct,
                                       input int n_items);
        int stop_at;
        int r;
        int len;
        int k;
        bit paused;
        logic [BYTE_W-1:0] x;
        wait_idle();
        write_reg(CFG_ESCAPE_CODE, esc_val);
        write_reg(CFG_START_CODE, start_val);
        src_idle_pct = src_pct;
        snk_stall_pct = snk_pct;
        stop_at = items_sent + n_items;
        paused = 1'b0;
        while (items_sent < stop_at)
        begin
            if (!paused && items_sent >= stop_at - n_items / 2)
            begin
                wait_results_drained();
                paused = 1'b1;
            end
            r = $urandom_range(99);
            if (r < 60)
            begin
                k = $urandom_range(99);
                if (k < 85)
                    len = $urandom_range(12, 1);
                else if (k < 95)
                    len = $urandom_range(40, 13);
                else
                    len = $urandom_range(FRAME_MAX + 2, FRAME_MAX);
                send_frame(len);
            end
            else if (r < 75)
            begin
                // broken frame ending in a bad escape
                send_byte(esc_m);
                send_byte(start_m);
                len = $urandom_range(6);
                for (k = 0; k < len; k++)
                    send_payload_byte(BYTE_W'($urandom_range(255)));
                do
                    x = BYTE_W'($urandom_range(255));
                while (x == esc_m || x == start_m);
                send_byte(esc_m);
                send_byte(x);
            end
            else if (r < 85)
                send_frame(0);
            else
            begin
                len = $urandom_range(4, 1);
                for (k = 0; k < len; k++)
                    send_byte(BYTE_W'($urandom_range(255)));
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_ESCAPE_CODE;
        cfg_data = '0;
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = '0;
        tx_ch.ready = 1'b0;
        esc_m = ESCAPE_CODE_RESET;
        start_m = START_CODE_RESET;
        phase_m = HUNT;
        fill_m = 0;
        mismatch_count = 0;
        cycle_count = 0;
        items_sent = 0;
        src_idle_pct = 0;
        snk_stall_pct = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_code_frames();
        test_overflow();
        test_equal_codes();
        test_random_traffic(ESCAPE_CODE_RESET, START_CODE_RESET, 0, 0, 10);
        test_random_traffic(8'h00, 8'hFF, 46, 0, 10);
        test_random_traffic(8'hFF, 8'h00, 0, 46, 10);
        test_random_traffic(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
                            30, 30, 10);

        rx_ch.valid = 1'b0;
        while (expected_payload.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
        if (mismatch_count == 0 && expected_payload.size() == 0)
            $display("escape_framed_byte_deframer test passed");
        else
            $display("escape_framed_byte_deframer test failed");
        $finish;
    end

endmodule
